// ===== sv/sliding_window_average_core_defines.svh =====
// Assertion macros used by the verification file of the block (swa_checker).
`ifndef SLIDING_WINDOW_AVERAGE_CORE_DEFINES_SVH
`define SLIDING_WINDOW_AVERAGE_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SWA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("swa assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define SWA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("swa assertion failed");

// Next-cycle implication that also holds through reset.
`define SWA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("swa assertion failed");

`endif

// ===== sv/swa_pkg.sv =====
`default_nettype none

package swa_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int WS_W            = 7;
    localparam logic [WS_W-1:0] WS_RESET = 7'd8;

endpackage

`default_nettype wire

// ===== sv/swa_if.sv =====
`default_nettype none

interface swa_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swa_average_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

interface swa_cfg_if import swa_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [WS_W-1:0] window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

`default_nettype wire

// ===== sv/swa_alu.sv =====
`default_nettype none

module swa_alu #(
    parameter int WIDTH = 23
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic             i_sub,
    output logic [WIDTH-1:0] o_y
);

    assign o_y = i_sub ? (i_a - i_b) : (i_a + i_b);

endmodule

`default_nettype wire

// ===== sv/swa_ram.sv =====
`default_nettype none

module swa_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/sliding_window_average_core.sv =====
// Moving-average filter over signed samples. Each request on the sample channel yields one
// average of the samples now held, truncated toward zero; the window length comes from the
// configuration register (zero acts as one, values above MAX_WINDOW act as MAX_WINDOW), and
// shrinking it below the number of held samples empties the window. A configuration request
// is taken only while the block is idle, no average waits on the output and no sample request
// is offered. A sample passes through the states S_EVICT (only when the oldest sample has to be
// dropped), S_ADD, S_ABS, S_DIV and S_FIN before the next ready; S_DIV is a bit-serial
// restoring divider, which shares the single adder with the running-sum update. The last step
// waits further for as long as the previous average has not been taken. A finished result
// may wait on the output while the next sample is taken.
`default_nettype none

module sliding_window_average_core import swa_pkg::*; #(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    swa_cfg_if.sink       i_cfg_if,
    swa_sample_if.sink    i_sample_if,
    swa_average_if.source o_average_if
);

    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + PTR_W;
    localparam int ALU_W = SUM_W + 1;
    localparam int EW    = (WS_W > CNT_W) ? WS_W : CNT_W;
    localparam int BIT_W = $clog2(SUM_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVICT,
        S_ADD,
        S_ABS,
        S_DIV,
        S_FIN
    } t_state;

    t_state                  r_state;
    logic [WS_W-1:0]         r_window;
    logic [SAMPLE_BITS-1:0]  r_sample;
    logic [PTR_W-1:0]        r_wp;
    logic [CNT_W-1:0]        r_held;
    logic [SUM_W-1:0]        r_sum;
    logic [SUM_W-1:0]        r_quo;
    logic [CNT_W-1:0]        r_rem;
    logic                    r_neg;
    logic [BIT_W-1:0]        r_bit;
    logic                    r_out_valid;
    logic [SAMPLE_BITS-1:0]  r_average;

    logic [CNT_W-1:0]        win_eff;
    logic [CNT_W-1:0]        cfg_eff;
    logic                    evict;
    logic [CNT_W:0]          oldest_raw;
    logic [PTR_W-1:0]        oldest;
    logic                    accept;
    logic                    cfg_write;
    logic                    out_free;
    logic [SAMPLE_BITS-1:0]  rdata;
    logic [CNT_W:0]          shifted;
    logic [ALU_W-1:0]        alu_a;
    logic [ALU_W-1:0]        alu_b;
    logic                    alu_sub;
    logic [ALU_W-1:0]        alu_y;

    function automatic logic [CNT_W-1:0] f_eff(input logic [WS_W-1:0] ws);
        logic [EW-1:0] ws_ext;
        ws_ext = EW'(ws);
        if (ws_ext == '0) begin
            return CNT_W'(1);
        end else if (ws_ext > EW'(MAX_WINDOW)) begin
            return CNT_W'(MAX_WINDOW);
        end else begin
            return ws_ext[CNT_W-1:0];
        end
    endfunction

    assign win_eff   = f_eff(r_window);
    assign cfg_eff   = f_eff(i_cfg_if.window_size);
    assign evict     = (r_held >= win_eff);
    assign accept    = i_sample_if.valid && i_sample_if.ready;
    assign cfg_write = i_cfg_if.valid && i_cfg_if.ready;
    assign out_free  = !r_out_valid || o_average_if.ready;
    assign shifted   = {r_rem, r_quo[SUM_W-1]};

    assign i_cfg_if.ready         = (r_state == S_IDLE) && !r_out_valid && !i_sample_if.valid;
    assign i_sample_if.ready      = (r_state == S_IDLE);
    assign o_average_if.valid     = r_out_valid;
    assign o_average_if.average   = r_average;

    always_comb begin
        oldest_raw = (CNT_W + 1)'(r_wp) + (CNT_W + 1)'(MAX_WINDOW) - (CNT_W + 1)'(r_held);
        if (oldest_raw >= (CNT_W + 1)'(MAX_WINDOW)) begin
            oldest_raw = oldest_raw - (CNT_W + 1)'(MAX_WINDOW);
        end
        oldest = oldest_raw[PTR_W-1:0];
    end

    swa_ram #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (SAMPLE_BITS)
    ) u_swa_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_ADD),
        .i_waddr (r_wp),
        .i_wdata (r_sample),
        .i_re    (accept && evict),
        .i_raddr (oldest),
        .o_rdata (rdata)
    );

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_EVICT: begin
                alu_a   = {r_sum[SUM_W-1], r_sum};
                alu_b   = {{(ALU_W - SAMPLE_BITS){rdata[SAMPLE_BITS-1]}}, rdata};
                alu_sub = 1'b1;
            end
            S_ADD: begin
                alu_a   = {r_sum[SUM_W-1], r_sum};
                alu_b   = {{(ALU_W - SAMPLE_BITS){r_sample[SAMPLE_BITS-1]}}, r_sample};
                alu_sub = 1'b0;
            end
            S_ABS: begin
                alu_b   = {r_sum[SUM_W-1], r_sum};
                alu_sub = 1'b1;
            end
            S_DIV: begin
                alu_a   = ALU_W'(shifted);
                alu_b   = ALU_W'(r_held);
                alu_sub = 1'b1;
            end
            S_FIN: begin
                alu_b   = {1'b0, r_quo};
                alu_sub = 1'b1;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
    end

    swa_alu #(
        .WIDTH (ALU_W)
    ) u_swa_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_y   (alu_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= WS_RESET;
            r_wp        <= '0;
            r_held      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_average_if.ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_write) begin
                r_window <= i_cfg_if.window_size;
                if (cfg_eff < r_held) begin
                    r_wp   <= '0;
                    r_held <= '0;
                    r_sum  <= '0;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_sample <= i_sample_if.sample;
                        r_state  <= evict ? S_EVICT : S_ADD;
                    end
                end
                S_EVICT: begin
                    r_sum   <= alu_y[SUM_W-1:0];
                    r_held  <= r_held - CNT_W'(1);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_sum   <= alu_y[SUM_W-1:0];
                    r_held  <= r_held + CNT_W'(1);
                    r_wp    <= (r_wp == PTR_W'(MAX_WINDOW - 1)) ? '0 : r_wp + PTR_W'(1);
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_neg   <= r_sum[SUM_W-1];
                    r_quo   <= r_sum[SUM_W-1] ? alu_y[SUM_W-1:0] : r_sum;
                    r_rem   <= '0;
                    r_bit   <= BIT_W'(SUM_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= alu_y[ALU_W-1] ? shifted[CNT_W-1:0] : alu_y[CNT_W-1:0];
                    r_quo <= {r_quo[SUM_W-2:0], ~alu_y[ALU_W-1]};
                    if (r_bit == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_bit <= r_bit - BIT_W'(1);
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_average   <= r_neg ? alu_y[SAMPLE_BITS-1:0] : r_quo[SAMPLE_BITS-1:0];
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/swa_checker.sv =====
`default_nettype none
`include "sliding_window_average_core_defines.svh"

module swa_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_out_average
);

    `SWA_ASSERT_NEXT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n, !i_out_valid)
    `SWA_ASSERT_NEXT(a_busy_after_request, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `SWA_ASSERT_NOW(a_busy_only_on_request, i_clk, i_rst_n, $fell(i_in_ready), $past(i_in_valid && i_in_ready))
    `SWA_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_average))

endmodule

bind sliding_window_average_core swa_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_swa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_sample_if.valid),
    .i_in_ready    (i_sample_if.ready),
    .i_out_valid   (o_average_if.valid),
    .i_out_ready   (o_average_if.ready),
    .i_out_average (o_average_if.average)
);

`default_nettype wire
